/* rtl/core/lwbpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwbpd_pkg: shared definitions of the LRU write-back page directory
// Codes, port widths, parameter defaults and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package lwbpd_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned PageBitsDef = 20;
  localparam int unsigned OpW         = 2;
  localparam int unsigned PageW       = 20;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [OpW-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_FLUSHED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic flush_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic flush_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/lwbpd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwbpd_ctrl: sequencer of the page directory
// Accepts one item at a time, steps the access update or the flush walk.
// ----------------------------------------------------------------------------
module lwbpd_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [lwbpd_pkg::OpW-1:0]      operation_i,
  input  wire lwbpd_pkg::sts_t                sts_i,
  output lwbpd_pkg::cmd_t                     cmd_o
);
  import lwbpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_FLUSH  = 3'b100
  } state_e;

  state_e state_q, state_d;
  op_e    op;
  logic   accept;

  assign op         = op_e'(operation_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_READ, OP_WRITE: state_d = S_UPDATE;
            OP_FLUSH:          state_d = S_FLUSH;
            OP_NONE:           state_d = S_IDLE;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush_step = 1'b1;
          if (sts_i.empty || sts_i.flush_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lwbpd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwbpd_datapath: tag store, recency ranks and result register
// Parallel tag match at accept, rank update or flush step on command.
// ----------------------------------------------------------------------------
module lwbpd_datapath #(
  parameter int unsigned CAPACITY  = lwbpd_pkg::CapacityDef,
  parameter int unsigned PAGE_BITS = lwbpd_pkg::PageBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lwbpd_pkg::cmd_t                  cmd_i,
  output lwbpd_pkg::sts_t                       sts_o,
  input  wire logic [lwbpd_pkg::OpW-1:0]        operation_i,
  input  wire logic [lwbpd_pkg::PageW-1:0]      page_number_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [lwbpd_pkg::StatusW-1:0]         status_o,
  output logic                                  evicted_o,
  output logic [lwbpd_pkg::PageW-1:0]           victim_page_o,
  output logic                                  write_back_o,
  output logic                                  last_o
);
  import lwbpd_pkg::*;

  localparam int unsigned RankW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW  = (PAGE_BITS > PageW) ? PAGE_BITS : PageW;

  logic [PAGE_BITS-1:0] tag_q [CAPACITY];
  logic [RankW-1:0]     rank_q [CAPACITY];
  logic [CAPACITY-1:0]  valid_q, dirty_q;
  logic [CntW-1:0]      count_q, cnt_m1;

  logic [PAGE_BITS-1:0] page_q;
  logic                 write_q;
  logic [CAPACITY-1:0]  hit_vec_q, victim_vec_q, free_vec_q;
  logic [RankW-1:0]     hit_rank_q, flush_rank_q;
  logic                 full_q;

  logic                 out_valid_q;
  status_e              status_q;
  logic                 evicted_q, wb_q, last_q;
  logic [PageW-1:0]     victim_q;

  logic [ExtW-1:0]      page_ext, sel_ext;
  logic [PAGE_BITS-1:0] tag_in, sel_tag;
  logic [CAPACITY-1:0]  hit_vec, victim_vec, free_vec, flush_vec, sel_vec, tgt_vec;
  logic [RankW-1:0]     hit_rank;
  logic                 sel_dirty, is_hit, load;

  assign page_ext = ExtW'(page_number_i);
  assign tag_in   = page_ext[PAGE_BITS-1:0];
  assign cnt_m1   = count_q - 1'b1;
  assign free_vec = ~valid_q & (valid_q + 1'b1);
  assign is_hit   = |hit_vec_q;
  assign tgt_vec  = full_q ? victim_vec_q : free_vec_q;
  assign sel_vec  = cmd_i.flush_step ? flush_vec : victim_vec_q;
  assign load     = cmd_i.update || cmd_i.flush_step;

  always_comb begin
    hit_rank  = '0;
    sel_tag   = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]    = valid_q[i] && (tag_q[i] == tag_in);
      victim_vec[i] = valid_q[i] && (rank_q[i] == cnt_m1[RankW-1:0]);
      flush_vec[i]  = valid_q[i] && (rank_q[i] == flush_rank_q);
      hit_rank      = hit_rank | (rank_q[i] & {RankW{hit_vec[i]}});
    end
    for (int i = 0; i < CAPACITY; i++) begin
      sel_tag   = sel_tag | (tag_q[i] & {PAGE_BITS{sel_vec[i]}});
      sel_dirty = sel_dirty | (dirty_q[i] && sel_vec[i]);
    end
  end

  assign sel_ext = ExtW'(sel_tag);

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.flush_last = (flush_rank_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.update) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (is_hit) begin
            if (hit_vec_q[i]) begin
              rank_q[i]  <= '0;
              dirty_q[i] <= dirty_q[i] || write_q;
            end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
              rank_q[i] <= rank_q[i] + 1'b1;
            end
          end else if (tgt_vec[i]) begin
            valid_q[i] <= 1'b1;
            dirty_q[i] <= write_q;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        if (!is_hit && !full_q) begin
          count_q <= count_q + 1'b1;
        end
      end else if (cmd_i.flush_step && !sts_o.empty && sts_o.flush_last) begin
        valid_q <= '0;
        dirty_q <= '0;
        count_q <= '0;
        for (int i = 0; i < CAPACITY; i++) begin
          rank_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q       <= tag_in;
      write_q      <= (op_e'(operation_i) == OP_WRITE);
      hit_vec_q    <= hit_vec;
      victim_vec_q <= victim_vec;
      free_vec_q   <= free_vec;
      hit_rank_q   <= hit_rank;
      full_q       <= (count_q >= CntW'(CAPACITY));
      flush_rank_q <= cnt_m1[RankW-1:0];
    end else if (cmd_i.flush_step) begin
      flush_rank_q <= flush_rank_q - 1'b1;
    end
    if (cmd_i.update && !is_hit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (tgt_vec[i]) begin
          tag_q[i] <= page_q;
        end
      end
    end
    if (cmd_i.update) begin
      status_q  <= is_hit ? ST_HIT : ST_MISS;
      evicted_q <= !is_hit && full_q;
      victim_q  <= (!is_hit && full_q) ? sel_ext[PageW-1:0] : '0;
      wb_q      <= !is_hit && full_q && sel_dirty;
      last_q    <= 1'b1;
    end else if (cmd_i.flush_step) begin
      if (sts_o.empty) begin
        status_q  <= ST_EMPTY;
        evicted_q <= 1'b0;
        victim_q  <= '0;
        wb_q      <= 1'b0;
        last_q    <= 1'b1;
      end else begin
        status_q  <= ST_FLUSHED;
        evicted_q <= 1'b1;
        victim_q  <= sel_ext[PageW-1:0];
        wb_q      <= sel_dirty;
        last_q    <= sts_o.flush_last;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign evicted_o     = evicted_q;
  assign victim_page_o = victim_q;
  assign write_back_o  = wb_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

/* rtl/core/lru_write_back_page_directory.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_write_back_page_directory: fully associative LRU write-back page directory
// Tracks resident pages, recency order and dirty state; reports fills,
// evictions with write-back, and flushes least recent first.
// ----------------------------------------------------------------------------
// One item is taken at a time, whenever the directory is idle, even while a
// result still waits in the output register. For a read or write access, all
// CAPACITY tags are compared in parallel in the cycle the item is accepted,
// and the recency ranks, fill and result are updated in the update state,
// which waits while the output register is still occupied. A flush follows
// the accept with one step per resident page, least recent first, or with a
// single step for the empty marker; a step stalls only while the output register
// holds a result that is not taken in that cycle. Operation code 3 is accepted
// and dropped with no result.
module lru_write_back_page_directory #(
  parameter int unsigned CAPACITY  = lwbpd_pkg::CapacityDef,
  parameter int unsigned PAGE_BITS = lwbpd_pkg::PageBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [lwbpd_pkg::OpW-1:0]        operation_i,
  input  wire logic [lwbpd_pkg::PageW-1:0]      page_number_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [lwbpd_pkg::StatusW-1:0]         status_o,
  output logic                                  evicted_o,
  output logic [lwbpd_pkg::PageW-1:0]           victim_page_o,
  output logic                                  write_back_o,
  output logic                                  last_o
);
  import lwbpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lwbpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lwbpd_datapath #(
    .CAPACITY  (CAPACITY),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .page_number_i (page_number_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .evicted_o     (evicted_o),
    .victim_page_o (victim_page_o),
    .write_back_o  (write_back_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

/* rtl/core/lwbpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwbpd_checker: port-level checks of the page directory
// Result consistency and output hold, bound to the top level.
// ----------------------------------------------------------------------------
module lwbpd_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_o,
  input  wire logic [lwbpd_pkg::OpW-1:0]        operation_i,
  input  wire logic [lwbpd_pkg::PageW-1:0]      page_number_i,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  input  wire logic [lwbpd_pkg::StatusW-1:0]    status_o,
  input  wire logic                             evicted_o,
  input  wire logic [lwbpd_pkg::PageW-1:0]      victim_page_o,
  input  wire logic                             write_back_o,
  input  wire logic                             last_o
);
  import lwbpd_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ in_ready_o ^ (^operation_i) ^ (^page_number_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(victim_page_o) && $stable(last_o))
    else $error("result changed before transfer");

  a_evict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> (status_o == ST_MISS || status_o == ST_FLUSHED))
    else $error("eviction on hit or empty flush");

  a_quiet_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_HIT || status_o == ST_EMPTY) |->
      !evicted_o && !write_back_o && victim_page_o == '0)
    else $error("hit or empty flush carries a victim");

  a_wb_needs_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_back_o |-> evicted_o)
    else $error("write-back without eviction");

  a_access_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_HIT || status_o == ST_MISS || status_o == ST_EMPTY)
      |-> last_o)
    else $error("single result not marked last");

endmodule

bind lru_write_back_page_directory lwbpd_checker u_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU write-back page directory
// Drives a directed table of accesses and flushes, then random traffic over a
// small page pool so that hits, evictions and full flushes recur. A shadow
// directory predicts every result; results are compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import lwbpd_pkg::*;

  localparam int unsigned Slots       = CapacityDef;
  localparam int unsigned RandomItems = 320;
  localparam int unsigned PoolSize    = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumDirected = 27;

  typedef struct packed {
    status_e          status;
    logic             evicted;
    logic [PageW-1:0] victim;
    logic             write_back;
    logic             last;
  } dir_result_t;

  typedef struct packed {
    op_e              op;
    logic [PageW-1:0] page;
    logic             typed;
    dir_result_t      want;
  } dir_row_t;

  localparam dir_result_t Empty  = '{ST_EMPTY, 1'b0, 20'h0, 1'b0, 1'b1};
  localparam dir_result_t Fill   = '{ST_MISS, 1'b0, 20'h0, 1'b0, 1'b1};
  localparam dir_result_t Hit    = '{ST_HIT, 1'b0, 20'h0, 1'b0, 1'b1};
  localparam dir_result_t NoWant = '0;

  localparam dir_row_t DirectedRows [NumDirected] = '{
    '{OP_FLUSH, 20'h00000, 1'b1, Empty},
    '{OP_READ,  20'h00000, 1'b1, Fill},
    '{OP_WRITE, 20'hFFFFF, 1'b1, Fill},
    '{OP_READ,  20'h00000, 1'b1, Hit},
    '{OP_WRITE, 20'h00000, 1'b1, Hit},
    '{OP_NONE,  20'h12345, 1'b0, NoWant},
    '{OP_FLUSH, 20'h00000, 1'b0, NoWant},
    '{OP_FLUSH, 20'hFFFFF, 1'b1, Empty},
    '{OP_WRITE, 20'hAAAAA, 1'b1, Fill},
    '{OP_READ,  20'h55555, 1'b1, Fill},
    '{OP_WRITE, 20'h00001, 1'b1, Fill},
    '{OP_READ,  20'h00002, 1'b1, Fill},
    '{OP_WRITE, 20'h00004, 1'b1, Fill},
    '{OP_READ,  20'h00008, 1'b1, Fill},
    '{OP_WRITE, 20'h00010, 1'b1, Fill},
    '{OP_READ,  20'h00020, 1'b1, Fill},
    '{OP_WRITE, 20'h00040, 1'b1, Fill},
    '{OP_READ,  20'h00080, 1'b1, Fill},
    '{OP_WRITE, 20'h0F0F0, 1'b1, Fill},
    '{OP_READ,  20'hF0F0F, 1'b1, Fill},
    '{OP_WRITE, 20'h12345, 1'b1, Fill},
    '{OP_READ,  20'h6789A, 1'b1, Fill},
    '{OP_WRITE, 20'h80000, 1'b1, Fill},
    '{OP_READ,  20'h7FFFF, 1'b1, Fill},
    '{OP_READ,  20'hFEDCB, 1'b0, NoWant},
    '{OP_READ,  20'h55555, 1'b0, NoWant},
    '{OP_FLUSH, 20'h00000, 1'b0, NoWant}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [OpW-1:0]     operation;
  logic [PageW-1:0]   page_number;
  logic               out_valid;
  logic               out_ready;
  logic [StatusW-1:0] status;
  logic               evicted;
  logic [PageW-1:0]   victim_page;
  logic               write_back;
  logic               last;

  logic [PageW-1:0] shadow_tag [Slots];
  logic             shadow_valid [Slots];
  logic             shadow_dirty [Slots];
  int unsigned      shadow_rank [Slots];
  int unsigned      shadow_count;

  dir_result_t      predicted [$];
  dir_result_t      pending_results [$];
  logic [PageW-1:0] page_pool [PoolSize];
  int unsigned      mismatch_count;
  int unsigned      burst_left;
  int unsigned      cycle_count;
  bit               hold_request;

  lru_write_back_page_directory i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (operation),
    .page_number_i(page_number),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .evicted_o    (evicted),
    .victim_page_o(victim_page),
    .write_back_o (write_back),
    .last_o       (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void lru_access(logic [PageW-1:0] page, logic is_write);
    int          hit_slot;
    int          free_slot;
    int unsigned old_rank;
    dir_result_t res;
    hit_slot  = -1;
    free_slot = -1;
    res       = Fill;
    for (int i = 0; i < Slots; i++) begin
      if (hit_slot < 0 && shadow_valid[i] && shadow_tag[i] == page) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      old_rank = shadow_rank[hit_slot];
      for (int i = 0; i < Slots; i++) begin
        if (shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
      end
      shadow_rank[hit_slot] = 0;
      if (is_write) shadow_dirty[hit_slot] = 1'b1;
      predicted.push_back(Hit);
      return;
    end
    if (shadow_count >= Slots) begin
      for (int i = 0; i < Slots; i++) begin
        if (!res.evicted && shadow_valid[i] && shadow_rank[i] == shadow_count - 1) begin
          res.evicted     = 1'b1;
          res.victim      = shadow_tag[i];
          res.write_back  = shadow_dirty[i];
          shadow_valid[i] = 1'b0;
          shadow_dirty[i] = 1'b0;
          shadow_rank[i]  = 0;
          shadow_count--;
        end
      end
    end
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[i]) begin
        shadow_rank[i]++;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot >= 0) begin
      shadow_tag[free_slot]   = page;
      shadow_valid[free_slot] = 1'b1;
      shadow_dirty[free_slot] = is_write;
      shadow_rank[free_slot]  = 0;
      shadow_count++;
    end
    predicted.push_back(res);
  endfunction

  function automatic void lru_flush();
    if (shadow_count == 0) begin
      predicted.push_back(Empty);
      return;
    end
    for (int unsigned r = shadow_count; r > 0; r--) begin
      for (int i = 0; i < Slots; i++) begin
        if (shadow_valid[i] && shadow_rank[i] == r - 1) begin
          predicted.push_back('{ST_FLUSHED, 1'b1, shadow_tag[i], shadow_dirty[i], 1'b0});
        end
      end
    end
    predicted[predicted.size() - 1].last = 1'b1;
    for (int i = 0; i < Slots; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    shadow_count = 0;
  endfunction

  function automatic void lru_predict(op_e op, logic [PageW-1:0] page);
    case (op)
      OP_READ:  lru_access(page, 1'b0);
      OP_WRITE: lru_access(page, 1'b1);
      OP_FLUSH: lru_flush();
      default:  ;
    endcase
  endfunction

  task automatic send_item(op_e op, logic [PageW-1:0] page, logic typed, dir_result_t want);
    in_valid    <= 1'b1;
    operation   <= op;
    page_number <= page;
    do @(posedge clk_i); while (!in_ready);
    lru_predict(op, page);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (predicted[i]) pending_results.push_back(predicted[i]);
    end
    predicted.delete();
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 15);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [PageW-1:0] want,
                                       logic [PageW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    dir_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual status %0d victim %h",
                 $time, status, victim_page);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", PageW'(want.status), PageW'(status));
        check_field("evicted", PageW'(want.evicted), PageW'(evicted));
        check_field("victim_page", want.victim, victim_page);
        check_field("write_back", PageW'(want.write_back), PageW'(write_back));
        check_field("last", PageW'(want.last), PageW'(last));
      end
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned mode;
    hold_left  = 0;
    phase_left = 0;
    mode       = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
        out_ready   <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 3);
          phase_left = $urandom_range(8, 60);
        end
        phase_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= phase_left[1];
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned issued;
    int unsigned roll;
    op_e         op;
    logic [PageW-1:0] page;
    mismatch_count = 0;
    hold_request   = 1'b0;
    burst_left     = 0;
    shadow_count   = 0;
    for (int i = 0; i < Slots; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    rst_ni      <= 1'b0;
    in_valid    <= 1'b0;
    operation   <= OP_READ;
    page_number <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      send_item(DirectedRows[i].op, DirectedRows[i].page, DirectedRows[i].typed,
                DirectedRows[i].want);
      pace_sender();
    end
    wait_drained();

    issued = 0;
    while (issued < RandomItems) begin
      if (issued % 80 == 0) begin
        foreach (page_pool[i]) page_pool[i] = PageW'($urandom());
      end
      if (issued == 100) hold_request = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 4) op = OP_FLUSH;
      else if (roll < 7) op = OP_NONE;
      else if (roll < 50) op = OP_WRITE;
      else op = OP_READ;
      if ($urandom_range(0, 99) < 85) page = page_pool[$urandom_range(0, PoolSize - 1)];
      else page = PageW'($urandom());
      send_item(op, page, 1'b0, NoWant);
      if (op != OP_NONE) issued++;
      if (issued == 200 && op != OP_NONE) begin
        wait_drained();
      end else begin
        pace_sender();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lwbpd_pkg.sv
rtl/core/lwbpd_ctrl.sv
rtl/core/lwbpd_datapath.sv
rtl/core/lru_write_back_page_directory.sv
rtl/core/lwbpd_checker.sv
tb/testbench.sv
